// ===== rtl/srtf_job_scheduler_macros.svh =====
// assertion macros of the scheduler rtl
`ifndef SRTF_JOB_SCHEDULER_MACROS_SVH
`define SRTF_JOB_SCHEDULER_MACROS_SVH

// same-cycle implication, checked on every rising clock outside reset
`define SRTF_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock outside reset
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/srtf_pkg.sv =====
// shared constants and types of the srtf job scheduler
`timescale 1ns / 1ps

package srtf_pkg;

   localparam int DEF_MAX_JOBS  = 16;
   localparam int DEF_TIME_BITS = 16;

   // fixed field widths on the stream ports
   localparam int SLOT_W  = 4;
   localparam int FIELD_W = 16;

   // req_tuser codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // control from the sequencer to every slot cell
   typedef struct packed {
      logic load_en;
      logic scan_en;
      logic dec_en;
      logic inc_valid;
   } cell_ctrl_type;

endpackage

// ===== rtl/srtf_job_scheduler.sv =====
// a result passes the scan, update and report states before it is registered on rsp
// the scan walks the chain of slot cells one cell per cycle, then the update and
// report states follow; a new beat is taken only once the report state is left
// a new beat is taken while the previous result still waits on rsp_tready
// reset (synchronous, active high) empties every slot and zeroes the clock
`timescale 1ns / 1ps
`include "srtf_job_scheduler_macros.svh"

module srtf_job_scheduler
   import srtf_pkg::*;
#(
   parameter int MAX_JOBS  = DEF_MAX_JOBS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot [3:0], burst_time [19:4], arrival_time [35:20], zero [39:36]
   input  logic [39:0] req_tdata,
   // action [0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // ran_valid [0], ran_slot [4:1], finished [5], waiting_time [21:6],
   // turnaround_time [37:22], clock_time [53:38], all_done [54], zero [55]
   output logic [55:0] rsp_tdata
);

   localparam int IDX_W      = $clog2(MAX_JOBS);
   localparam int EXT_W      = FIELD_W + TIME_BITS;
   localparam int PICK_EXT_W = IDX_W + SLOT_W;
   localparam int RSP_RAN    = 0;
   localparam int RSP_FIN    = 5;
   localparam int RSP_DONE   = 54;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_CALC = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 act_ff, act_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic                 inc_valid_ff, inc_valid_in;
   logic [IDX_W-1:0]     inc_slot_ff, inc_slot_in;
   logic [TIME_BITS:0]   diff_ff, diff_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0]          rsp_tdata_ff, rsp_tdata_in;

   logic                 req_beat, slot_ok, load_hits_inc;
   logic [EXT_W-1:0]     burst_ext, arr_ext;
   logic [TIME_BITS-1:0] now_next;
   cell_ctrl_type        ctrl;

   logic                 found_c [MAX_JOBS+1];
   logic [IDX_W-1:0]     pick_c  [MAX_JOBS+1];
   logic [TIME_BITS-1:0] best_c  [MAX_JOBS+1];
   logic [TIME_BITS-1:0] burst_c [MAX_JOBS+1];
   logic [TIME_BITS-1:0] arr_c   [MAX_JOBS+1];
   logic [1:0]           nz_c    [MAX_JOBS+1];

   logic                    found_l;
   logic [IDX_W-1:0]        pick_l;
   logic [TIME_BITS-1:0]    best_l, burst_l, arr_l;
   logic [1:0]              nz_l;
   logic signed [TIME_BITS+1:0] wait_full;
   logic [TIME_BITS:0]      wait_pos, tat_pos;
   logic [EXT_W:0]          wait_ext, tat_ext, now_ext;
   logic [PICK_EXT_W-1:0]   pick_ext;
   logic                    ran, fin, done;

   assign req_beat  = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign slot_ok   = int'(req_tdata[3:0]) < MAX_JOBS;
   assign burst_ext = EXT_W'(req_tdata[19:4]);
   assign arr_ext   = EXT_W'(req_tdata[35:20]);
   assign load_hits_inc = req_beat && (req_tuser == ACT_LOAD) && slot_ok && inc_valid_ff &&
                          (int'(req_tdata[3:0]) == int'(inc_slot_ff));

   // scan result at the tail of the chain
   assign found_l = found_c[MAX_JOBS];
   assign pick_l  = pick_c[MAX_JOBS];
   assign best_l  = best_c[MAX_JOBS];
   assign burst_l = burst_c[MAX_JOBS];
   assign arr_l   = arr_c[MAX_JOBS];
   assign nz_l    = nz_c[MAX_JOBS];

   assign ctrl.load_en   = req_beat && (req_tuser == ACT_LOAD) && slot_ok;
   assign ctrl.scan_en   = (state_ff == S_SCAN);
   assign ctrl.dec_en    = (state_ff == S_CALC) && (act_ff == ACT_TICK) && found_l;
   assign ctrl.inc_valid = inc_valid_ff;

   assign found_c[0] = 1'b0;
   assign pick_c[0]  = '0;
   assign best_c[0]  = '0;
   assign burst_c[0] = '0;
   assign arr_c[0]   = '0;
   assign nz_c[0]    = 2'd0;

   for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
      srtf_cell #(
         .MAX_JOBS  (MAX_JOBS),
         .TIME_BITS (TIME_BITS),
         .CELL_IDX  (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .load_slot    (req_tdata[3:0]),
         .load_burst   (burst_ext[TIME_BITS-1:0]),
         .load_arrival (arr_ext[TIME_BITS-1:0]),
         .dec_slot     (pick_l),
         .inc_slot     (inc_slot_ff),
         .now          (now_ff),
         .found_i      (found_c[g]),
         .pick_i       (pick_c[g]),
         .best_i       (best_c[g]),
         .burst_i      (burst_c[g]),
         .arr_i        (arr_c[g]),
         .nz_i         (nz_c[g]),
         .found_o      (found_c[g+1]),
         .pick_o       (pick_c[g+1]),
         .best_o       (best_c[g+1]),
         .burst_o      (burst_c[g+1]),
         .arr_o        (arr_c[g+1]),
         .nz_o         (nz_c[g+1])
      );
   end

   assign now_next = (now_ff == '1) ? now_ff : now_ff + 1'b1;

   // report fields
   assign ran       = (act_ff == ACT_TICK) && found_l;
   assign fin       = ran && (best_l == TIME_BITS'(1));
   assign wait_full = $signed({diff_ff[TIME_BITS], diff_ff}) - $signed({2'b00, burst_l});
   assign wait_pos  = wait_full[TIME_BITS+1] ? '0 : wait_full[TIME_BITS:0];
   assign tat_pos   = diff_ff[TIME_BITS] ? '0 : diff_ff;
   assign wait_ext  = (EXT_W+1)'(wait_pos);
   assign tat_ext   = (EXT_W+1)'(tat_pos);
   assign now_ext   = (EXT_W+1)'(now_ff);
   assign pick_ext  = PICK_EXT_W'(pick_l);
   // all_done: no slot is busy, or the finishing job was the last busy slot
   assign done      = (nz_l == 2'd0) || ((nz_l == 2'd1) && fin);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      act_in        = act_ff;
      now_in        = now_ff;
      inc_valid_in  = inc_valid_ff;
      inc_slot_in   = inc_slot_ff;
      diff_in       = diff_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               act_in   = req_tuser;
               cnt_in   = '0;
               state_in = S_SCAN;
               if (load_hits_inc) begin
                  inc_valid_in = 1'b0;
               end
            end
         end
         S_SCAN: begin
            if (cnt_ff == IDX_W'(MAX_JOBS - 1)) begin
               state_in = S_CALC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_CALC: begin
            if (act_ff == ACT_TICK) begin
               now_in  = now_next;
               diff_in = $signed({1'b0, now_next}) - $signed({1'b0, arr_l});
               if (found_l) begin
                  inc_slot_in  = pick_l;
                  inc_valid_in = (best_l != TIME_BITS'(1));
               end else begin
                  inc_valid_in = 1'b0;
               end
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, done, now_ext[FIELD_W-1:0],
                                fin ? tat_ext[FIELD_W-1:0] : {FIELD_W{1'b0}},
                                fin ? wait_ext[FIELD_W-1:0] : {FIELD_W{1'b0}},
                                fin,
                                ran ? pick_ext[SLOT_W-1:0] : {SLOT_W{1'b0}},
                                ran};
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         act_ff        <= ACT_LOAD;
         now_ff        <= '0;
         inc_valid_ff  <= 1'b0;
         inc_slot_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         act_ff        <= act_in;
         now_ff        <= now_in;
         inc_valid_ff  <= inc_valid_in;
         inc_slot_ff   <= inc_slot_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff      <= diff_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `SRTF_ASSERT_IMP(a_fin_needs_run, rsp_tvalid_ff && rsp_tdata_ff[RSP_FIN], rsp_tdata_ff[RSP_RAN], "finished flag without a running job")
   `SRTF_ASSERT_IMP(a_unfinished_not_done, rsp_tvalid_ff && rsp_tdata_ff[RSP_RAN] && !rsp_tdata_ff[RSP_FIN], !rsp_tdata_ff[RSP_DONE], "all_done while the running job has time left")
   `SRTF_ASSERT_NEXT(a_load_drops_inc, load_hits_inc, !inc_valid_ff, "reloaded incumbent slot kept the processor")
   `SRTF_ASSERT_NEXT(a_tick_moves_clock, (state_ff == S_CALC) && (act_ff == ACT_TICK), now_ff != '0, "clock wrapped on a tick")

endmodule

// ===== rtl/srtf_cell.sv =====
// one job slot of the scheduler chain: slot state and one compare stage of the scan
`timescale 1ns / 1ps

module srtf_cell
   import srtf_pkg::*;
#(
   parameter int MAX_JOBS  = DEF_MAX_JOBS,
   parameter int TIME_BITS = DEF_TIME_BITS,
   parameter int CELL_IDX  = 0,
   localparam int IDX_W    = $clog2(MAX_JOBS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic [SLOT_W-1:0]    load_slot,
   input  logic [TIME_BITS-1:0] load_burst,
   input  logic [TIME_BITS-1:0] load_arrival,
   input  logic [IDX_W-1:0]     dec_slot,
   input  logic [IDX_W-1:0]     inc_slot,
   input  logic [TIME_BITS-1:0] now,
   input  logic                 found_i,
   input  logic [IDX_W-1:0]     pick_i,
   input  logic [TIME_BITS-1:0] best_i,
   input  logic [TIME_BITS-1:0] burst_i,
   input  logic [TIME_BITS-1:0] arr_i,
   input  logic [1:0]           nz_i,
   output logic                 found_o,
   output logic [IDX_W-1:0]     pick_o,
   output logic [TIME_BITS-1:0] best_o,
   output logic [TIME_BITS-1:0] burst_o,
   output logic [TIME_BITS-1:0] arr_o,
   output logic [1:0]           nz_o
);

   logic [TIME_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0] burst_ff, burst_in;
   logic [TIME_BITS-1:0] arr_ff, arr_in;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [TIME_BITS-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0] cburst_ff, cburst_in;
   logic [TIME_BITS-1:0] carr_ff, carr_in;
   logic [1:0]           nz_ff, nz_in;

   logic load_hit, dec_hit, eligible, is_inc, take;

   assign load_hit = ctrl.load_en && (int'(load_slot) == CELL_IDX);
   assign dec_hit  = ctrl.dec_en && (dec_slot == IDX_W'(CELL_IDX));
   assign eligible = (arr_ff <= now) && (rem_ff != '0);
   assign is_inc   = ctrl.inc_valid && (inc_slot == IDX_W'(CELL_IDX));
   // the incumbent wins ties, otherwise the lower slot already carried wins
   assign take     = eligible &&
                     (!found_i || (rem_ff < best_i) || ((rem_ff == best_i) && is_inc));

   always_comb begin
      rem_in   = rem_ff;
      burst_in = burst_ff;
      arr_in   = arr_ff;
      if (load_hit) begin
         rem_in   = load_burst;
         burst_in = load_burst;
         arr_in   = load_arrival;
      end else if (dec_hit) begin
         rem_in = rem_ff - 1'b1;
      end
   end

   always_comb begin
      found_in  = found_ff;
      pick_in   = pick_ff;
      best_in   = best_ff;
      cburst_in = cburst_ff;
      carr_in   = carr_ff;
      nz_in     = nz_ff;
      if (ctrl.scan_en) begin
         if (take) begin
            found_in  = 1'b1;
            pick_in   = IDX_W'(CELL_IDX);
            best_in   = rem_ff;
            cburst_in = burst_ff;
            carr_in   = arr_ff;
         end else begin
            found_in  = found_i;
            pick_in   = pick_i;
            best_in   = best_i;
            cburst_in = burst_i;
            carr_in   = arr_i;
         end
         // count of busy slots so far, saturating at two
         if (rem_ff != '0) begin
            nz_in = (nz_i == 2'd0) ? 2'd1 : 2'd2;
         end else begin
            nz_in = nz_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         burst_ff  <= '0;
         arr_ff    <= '0;
         found_ff  <= 1'b0;
         pick_ff   <= '0;
         best_ff   <= '0;
         cburst_ff <= '0;
         carr_ff   <= '0;
         nz_ff     <= 2'd0;
      end else begin
         rem_ff    <= rem_in;
         burst_ff  <= burst_in;
         arr_ff    <= arr_in;
         found_ff  <= found_in;
         pick_ff   <= pick_in;
         best_ff   <= best_in;
         cburst_ff <= cburst_in;
         carr_ff   <= carr_in;
         nz_ff     <= nz_in;
      end
   end

   assign found_o = found_ff;
   assign pick_o  = pick_ff;
   assign best_o  = best_ff;
   assign burst_o = cburst_ff;
   assign arr_o   = carr_ff;
   assign nz_o    = nz_ff;

endmodule
